// ===== hdl/slpb_pkg.sv =====
`default_nettype none
package slpb_pkg;

  localparam int WAVE_TABLE_SIZE = 256;
  localparam int WAVE_IDX_BITS   = $clog2(WAVE_TABLE_SIZE);
  localparam int TIME_BITS       = 48;
  localparam int DIV_STEPS       = TIME_BITS + WAVE_IDX_BITS;
  localparam int CNT_BITS        = $clog2(DIV_STEPS + 1);
  localparam int LVL_BITS        = 24;
  localparam int REG_IDX_BITS    = 3;
  localparam int ADDR_BITS       = 5;

  localparam logic [23:0] GREEN_RGB = 24'h00FF00;

  // opcodes
  localparam logic [2:0] OP_SET_STATE  = 3'd0;
  localparam logic [2:0] OP_SET_HID    = 3'd1;
  localparam logic [2:0] OP_SET_LAYER  = 3'd2;
  localparam logic [2:0] OP_SET_SWITCH = 3'd3;
  localparam logic [2:0] OP_RENDER     = 3'd4;

  // state codes
  localparam logic [2:0] ST_WAIT      = 3'd0;
  localparam logic [2:0] ST_CONNECTED = 3'd1;
  localparam logic [2:0] ST_MIC_STRM  = 3'd2;
  localparam logic [2:0] ST_HID_PRESS = 3'd3;
  localparam logic [2:0] ST_MIC_PRESS = 3'd4;

  // register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_PERIOD   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MIN      = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX      = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_DURATION = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_FLASH    = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_CONN     = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_SOLID    = 3'd6;

  typedef enum logic [1:0] {
    MODE_DIRECT,
    MODE_SCALE,
    MODE_BREATH
  } mode_e;

  typedef struct packed {
    logic [23:0] period;
    logic [7:0]  min_lvl;
    logic [7:0]  max_lvl;
    logic [23:0] duration;
    logic [7:0]  flash_lvl;
    logic [7:0]  conn_lvl;
    logic [7:0]  solid_lvl;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       lvl_step;
    logic       mul_step;
    logic       scl_step;
    logic       emit;
    logic [1:0] ch_sel;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
  } sts_t;

  typedef logic [15:0] wave_t [WAVE_TABLE_SIZE];

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // cos(u), u in [0, pi/2], Q30 in and out
  function automatic logic [63:0] cos_q30(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] acc;
    u2  = (u * u) >> 30;
    acc = ONE_Q30;
    acc = ONE_Q30 - ((u2 * acc) >> 30) / 64'd132;
    acc = ONE_Q30 - ((u2 * acc) >> 30) / 64'd90;
    acc = ONE_Q30 - ((u2 * acc) >> 30) / 64'd56;
    acc = ONE_Q30 - ((u2 * acc) >> 30) / 64'd30;
    acc = ONE_Q30 - ((u2 * acc) >> 30) / 64'd12;
    acc = ONE_Q30 - ((u2 * acc) >> 30) / 64'd2;
    return acc;
  endfunction

  function automatic wave_t build_wave();
    wave_t       tab;
    logic [63:0] n;
    logic [63:0] j;
    logic [63:0] w;
    n = 64'(WAVE_TABLE_SIZE);
    for (int i = 0; i < WAVE_TABLE_SIZE; i++) begin
      j = (64'(i) <= n - 64'(i)) ? 64'(i) : n - 64'(i);
      if (4 * j <= n) begin
        w = ONE_Q30 - cos_q30((j * 64'd2 * PI_Q30) / WAVE_TABLE_SIZE);
      end else begin
        w = ONE_Q30 + cos_q30(((n - 64'd2 * j) * PI_Q30) / WAVE_TABLE_SIZE);
      end
      w = w >> 1;
      tab[i] = 16'((w + (64'd1 << 15)) >> 16);
    end
    return tab;
  endfunction

  localparam wave_t WAVE_TAB = build_wave();

  // floor(y / 255), exact for any 16-bit y below 255 * 256
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [31:0] p;
    p = 32'(y) * 32'h8081;
    return p[30:23];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/status_led_priority_breathing.sv =====
// Status LED controller. Events come in on the slave stream with the opcode in
// tuser; only a render (opcode 4) produces a result, one RGB item on the master
// stream. Set-state, HID-flag, layer-colour and switch-mode events leave the
// block ready again at once. A solid state colour render goes straight to the
// output register, a flash or connected-colour render does one multiply and one
// divide-by-255 step per channel, and a breathing render gets its phase index
// from a 1-bit-per-cycle restoring divider that runs TIME_BITS + 8 = 56 steps
// over the timestamp. The input is taken while the previous result still waits
// in the output register. Registers sit on the APB port at byte address 4*i; the
// user must write them only while idle, which the block does not enforce.
`default_nettype none
module status_led_priority_breathing (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input events
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: state_code[2:0], flag_value[3], rgb_value[27:4], now_us[75:28], zero pad
  input  wire logic [79:0] s_axis_tdata,
  // tuser: opcode[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  // render results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: red[7:0], green[15:8], blue[23:16]
  output logic [23:0]      m_axis_tdata,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  slpb_pkg::cfg_t cfg;
  slpb_pkg::cmd_t cmd;
  slpb_pkg::sts_t sts;

  slpb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: one render at a time, output register parts the two sides
  slpb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .opcode_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // state, divider, level and channel scaling
  slpb_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (s_axis_tuser),
    .state_code_i (s_axis_tdata[2:0]),
    .flag_value_i (s_axis_tdata[3]),
    .rgb_value_i  (s_axis_tdata[27:4]),
    .now_us_i     (s_axis_tdata[75:28]),
    .out_data_o   (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ===== hdl/slpb_cfg_regs.sv =====
`default_nettype none
module slpb_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [slpb_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output slpb_pkg::cfg_t                     cfg_o
);

  slpb_pkg::cfg_t cfg_q;
  logic [slpb_pkg::REG_IDX_BITS-1:0] idx;
  logic wr;

  assign idx    = paddr[slpb_pkg::ADDR_BITS-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period    <= 24'd1500000;
      cfg_q.min_lvl   <= 8'd6;
      cfg_q.max_lvl   <= 8'd40;
      cfg_q.duration  <= 24'd200000;
      cfg_q.flash_lvl <= 8'd36;
      cfg_q.conn_lvl  <= 8'd20;
      cfg_q.solid_lvl <= 8'd24;
    end else if (wr) begin
      case (idx)
        slpb_pkg::REG_PERIOD:   cfg_q.period    <= pwdata[23:0];
        slpb_pkg::REG_MIN:      cfg_q.min_lvl   <= pwdata[7:0];
        slpb_pkg::REG_MAX:      cfg_q.max_lvl   <= pwdata[7:0];
        slpb_pkg::REG_DURATION: cfg_q.duration  <= pwdata[23:0];
        slpb_pkg::REG_FLASH:    cfg_q.flash_lvl <= pwdata[7:0];
        slpb_pkg::REG_CONN:     cfg_q.conn_lvl  <= pwdata[7:0];
        slpb_pkg::REG_SOLID:    cfg_q.solid_lvl <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      slpb_pkg::REG_PERIOD:   prdata = {8'd0, cfg_q.period};
      slpb_pkg::REG_MIN:      prdata = {24'd0, cfg_q.min_lvl};
      slpb_pkg::REG_MAX:      prdata = {24'd0, cfg_q.max_lvl};
      slpb_pkg::REG_DURATION: prdata = {8'd0, cfg_q.duration};
      slpb_pkg::REG_FLASH:    prdata = {24'd0, cfg_q.flash_lvl};
      slpb_pkg::REG_CONN:     prdata = {24'd0, cfg_q.conn_lvl};
      slpb_pkg::REG_SOLID:    prdata = {24'd0, cfg_q.solid_lvl};
      default:                prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/slpb_ctrl.sv =====
`default_nettype none
module slpb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [2:0]     opcode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire slpb_pkg::sts_t sts_i,
  output slpb_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_LVL,
    S_MUL,
    S_SCL,
    S_OUT
  } state_e;

  state_e                      state_q;
  logic [slpb_pkg::CNT_BITS-1:0] cnt_q;
  logic [1:0]                  ch_q;
  logic                        out_valid_q;
  logic                        accept;
  logic                        out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = ~out_valid_q | out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.lvl_step = (state_q == S_LVL);
    cmd_o.mul_step = (state_q == S_MUL);
    cmd_o.scl_step = (state_q == S_SCL);
    cmd_o.emit     = (state_q == S_OUT) & out_free;
    cmd_o.ch_sel   = ch_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && opcode_i == slpb_pkg::OP_RENDER) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          cnt_q <= '0;
          ch_q  <= '0;
          case (sts_i.mode)
            slpb_pkg::MODE_BREATH: state_q <= S_DIV;
            slpb_pkg::MODE_SCALE:  state_q <= S_MUL;
            default:               state_q <= S_OUT;
          endcase
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == slpb_pkg::CNT_BITS'(slpb_pkg::DIV_STEPS - 1)) state_q <= S_LVL;
        end
        S_LVL: state_q <= S_MUL;
        S_MUL: state_q <= S_SCL;
        S_SCL: begin
          if (ch_q == 2'd2) begin
            state_q <= S_OUT;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/slpb_datapath.sv =====
`default_nettype none
module slpb_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire slpb_pkg::cfg_t                 cfg_i,
  input  wire slpb_pkg::cmd_t                 cmd_i,
  output slpb_pkg::sts_t                      sts_o,
  input  wire logic [2:0]                     opcode_i,
  input  wire logic [2:0]                     state_code_i,
  input  wire logic                           flag_value_i,
  input  wire logic [23:0]                    rgb_value_i,
  input  wire logic [slpb_pkg::TIME_BITS-1:0] now_us_i,
  output logic      [23:0]                    out_data_o
);

  localparam int TB = slpb_pkg::TIME_BITS;
  localparam int WB = slpb_pkg::WAVE_IDX_BITS;
  localparam int LB = slpb_pkg::LVL_BITS;

  // persistent state
  logic [2:0]    base_q;
  logic          hid_q, seen_q, sw_q, flash_q;
  logic [23:0]   layer_q;
  logic [TB-1:0] exp_q;

  // per-render working registers
  slpb_pkg::mode_e mode_q;
  logic [23:0]     color_q;
  logic [LB-1:0]   lvl_q;
  logic [23:0]     res_q;
  logic [23:0]     out_q;
  logic [TB+WB-1:0] dvd_q;
  logic [24:0]     rem_q;
  logic [23:0]     per_q;
  logic [WB-1:0]   idx_q;
  logic [31:0]     prod_q;

  logic          expired, flash_now;
  logic [TB:0]   exp_sum;
  logic [TB-1:0] exp_new;
  logic [24:0]   rem_sh;
  logic          rem_ge;
  logic [15:0]   wave;
  logic [23:0]   wprod;
  logic [LB-1:0] lvl_base;
  logic [7:0]    c_sel;
  logic [7:0]    s;
  logic [7:0]    ch_val;

  assign sts_o.mode = mode_q;
  assign out_data_o = out_q;
  assign s          = cfg_i.solid_lvl;

  assign expired   = now_us_i > exp_q;
  assign flash_now = flash_q & ~expired;
  assign exp_sum   = {1'b0, now_us_i} + (TB+1)'(cfg_i.duration);
  assign exp_new   = exp_sum[TB] ? {TB{1'b1}} : exp_sum[TB-1:0];

  // one restoring division step
  assign rem_sh = {rem_q[23:0], dvd_q[TB+WB-1]};
  assign rem_ge = rem_sh >= {1'b0, per_q};

  assign wave     = slpb_pkg::WAVE_TAB[idx_q];
  assign lvl_base = LB'(cfg_i.min_lvl) << 15;
  always_comb begin
    if (cfg_i.max_lvl >= cfg_i.min_lvl) begin
      wprod = 24'(cfg_i.max_lvl - cfg_i.min_lvl) * 24'(wave);
    end else begin
      wprod = 24'(cfg_i.min_lvl - cfg_i.max_lvl) * 24'(wave);
    end
  end

  always_comb begin
    case (cmd_i.ch_sel)
      2'd0:    c_sel = color_q[23:16];
      2'd1:    c_sel = color_q[15:8];
      default: c_sel = color_q[7:0];
    endcase
  end

  assign ch_val = slpb_pkg::div255(prod_q[30:15]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= slpb_pkg::ST_WAIT;
      hid_q   <= 1'b0;
      layer_q <= slpb_pkg::GREEN_RGB;
      seen_q  <= 1'b0;
      sw_q    <= 1'b0;
      flash_q <= 1'b0;
      exp_q   <= '0;
    end else if (cmd_i.load) begin
      case (opcode_i)
        slpb_pkg::OP_SET_STATE: begin
          if (state_code_i != slpb_pkg::ST_HID_PRESS &&
              state_code_i != slpb_pkg::ST_MIC_PRESS) begin
            flash_q <= 1'b0;
            base_q  <= state_code_i;
          end
        end
        slpb_pkg::OP_SET_HID: hid_q <= flag_value_i;
        slpb_pkg::OP_SET_LAYER: begin
          layer_q <= (rgb_value_i != 24'd0) ? rgb_value_i : slpb_pkg::GREEN_RGB;
          seen_q  <= 1'b1;
          exp_q   <= exp_new;
          flash_q <= 1'b1;
        end
        slpb_pkg::OP_SET_SWITCH: sw_q <= flag_value_i;
        slpb_pkg::OP_RENDER: begin
          if (expired) flash_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // layer_q is never zero, so it serves the breathing color as it is
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && opcode_i == slpb_pkg::OP_RENDER) begin
      dvd_q   <= {now_us_i, {WB{1'b0}}};
      rem_q   <= '0;
      per_q   <= (cfg_i.period != 24'd0) ? cfg_i.period : 24'd1;
      color_q <= layer_q;
      if (flash_now) begin
        if (seen_q) begin
          mode_q <= slpb_pkg::MODE_SCALE;
          lvl_q  <= LB'(cfg_i.flash_lvl) << 15;
        end else begin
          mode_q <= slpb_pkg::MODE_DIRECT;
          res_q  <= {8'd0, 8'd0, s};
        end
      end else if (sw_q) begin
        mode_q  <= slpb_pkg::MODE_BREATH;
      end else if (base_q == slpb_pkg::ST_MIC_STRM) begin
        mode_q <= slpb_pkg::MODE_DIRECT;
        res_q  <= {s, 8'd0, 8'd0};
      end else if (hid_q) begin
        mode_q <= slpb_pkg::MODE_DIRECT;
        res_q  <= {8'd0, s, s};
      end else if (base_q == slpb_pkg::ST_WAIT) begin
        mode_q <= slpb_pkg::MODE_DIRECT;
        res_q  <= {8'd0, 8'd0, s};
      end else if (base_q == slpb_pkg::ST_CONNECTED) begin
        mode_q <= slpb_pkg::MODE_SCALE;
        lvl_q  <= LB'(cfg_i.conn_lvl) << 15;
      end else begin
        mode_q <= slpb_pkg::MODE_DIRECT;
        res_q  <= '0;
      end
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[TB+WB-2:0], 1'b0};
      rem_q <= rem_ge ? rem_sh - {1'b0, per_q} : rem_sh;
      idx_q <= {idx_q[WB-2:0], rem_ge};
    end
    if (cmd_i.lvl_step) begin
      if (cfg_i.max_lvl >= cfg_i.min_lvl) lvl_q <= lvl_base + wprod;
      else                                 lvl_q <= lvl_base - wprod;
    end
    if (cmd_i.mul_step) prod_q <= 32'(c_sel) * 32'(lvl_q);
    if (cmd_i.scl_step) begin
      case (cmd_i.ch_sel)
        2'd0:    res_q[7:0]   <= ch_val;
        2'd1:    res_q[15:8]  <= ch_val;
        default: res_q[23:16] <= ch_val;
      endcase
    end
    if (cmd_i.emit) out_q <= res_q;
  end

endmodule
`default_nettype wire

// ===== hdl/slpb_checker.sv =====
`default_nettype none
module slpb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [2:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        pready
);

  logic acc;
  assign acc = s_axis_tvalid & s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_render_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser == slpb_pkg::OP_RENDER |=> !s_axis_tready)
    else $error("ready right after a render request");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser != slpb_pkg::OP_RENDER |=> !$rose(m_axis_tvalid))
    else $error("result after a non-render request");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind status_led_priority_breathing slpb_checker u_slpb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);
`default_nettype wire

// ===== tb/status_led_priority_breathing_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module status_led_priority_breathing_test;

  // Bounds on the time stamps and the run.
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int          N_RANDOM = 700;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  status_led_priority_breathing u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  // One LED event request.
  typedef struct {
    logic [2:0]  op;
    logic [2:0]  code;
    logic        flag;
    logic [23:0] rgb;
    logic [47:0] now;
  } led_event_t;

  led_event_t  event_q[$];       // requests waiting for the driver
  logic [23:0] rgb_expected_q[$]; // predicted colors, oldest first
  int          n_errors = 0;
  int          n_renders = 0;
  int          n_events = 0;

  // Predictor copy of the registers and state.
  logic [23:0] m_period, m_duration;
  logic [7:0]  m_min, m_max, m_flash, m_conn, m_solid;
  logic [2:0]  m_base;
  logic        m_hid, m_seen, m_switch, m_flash_on;
  logic [23:0] m_layer;
  logic [47:0] m_expiry;
  logic [15:0] wave_q15 [slpb_pkg::WAVE_TABLE_SIZE];

  // Q30 cosine series for u in [0, pi/2].
  function automatic logic [63:0] cosine_q30(logic [63:0] u);
    logic [63:0] u2, acc;
    int divs [6];
    divs = '{132, 90, 56, 30, 12, 2};
    u2 = (u * u) >> 30;
    acc = 64'd1 << 30;
    for (int k = 0; k < 6; k++)
      acc = (64'd1 << 30) - ((u2 * acc) >> 30) / 64'(divs[k]);
    return acc;
  endfunction

  task automatic fill_wave();
    logic [63:0] n, j, w;
    n = 64'(slpb_pkg::WAVE_TABLE_SIZE);
    for (int i = 0; i < slpb_pkg::WAVE_TABLE_SIZE; i++) begin
      j = (64'(i) <= n - 64'(i)) ? 64'(i) : n - 64'(i);
      if (4 * j <= n)
        w = (64'd1 << 30) - cosine_q30((j * 64'd2 * 64'd3373259426) / n);
      else
        w = (64'd1 << 30) + cosine_q30(((n - 64'd2 * j) * 64'd3373259426) / n);
      w = w >> 1;
      wave_q15[i] = 16'((w + (64'd1 << 15)) >> 16);
    end
  endtask

  function automatic logic [7:0] scale8(logic [7:0] c, logic [7:0] lvl);
    return 8'((32'(c) * 32'(lvl)) / 255);
  endfunction

  function automatic logic [23:0] scale_rgb(logic [23:0] c, logic [7:0] lvl);
    // tdata order: red low, blue high
    return {scale8(c[7:0], lvl), scale8(c[15:8], lvl), scale8(c[23:16], lvl)};
  endfunction

  // Applies one event to the model; returns 1 and the color on a render.
  function automatic bit predict_led(led_event_t e, output logic [23:0] rgb);
    logic [48:0]  exp;
    logic [63:0]  per, idx, lvl;
    logic [23:0]  c;
    logic [7:0]   ch [3];
    rgb = '0;
    case (e.op)
      slpb_pkg::OP_SET_STATE: begin
        if (e.code != slpb_pkg::ST_HID_PRESS && e.code != slpb_pkg::ST_MIC_PRESS) begin
          m_flash_on = 1'b0;
          m_base = e.code;
        end
      end
      slpb_pkg::OP_SET_HID:    m_hid = e.flag;
      slpb_pkg::OP_SET_SWITCH: m_switch = e.flag;
      slpb_pkg::OP_SET_LAYER: begin
        exp = 49'(e.now) + 49'(m_duration);
        m_expiry = exp[48] ? TIME_MAX : exp[47:0];
        m_layer = (e.rgb == 0) ? slpb_pkg::GREEN_RGB : e.rgb;
        m_seen = 1'b1;
        m_flash_on = 1'b1;
      end
      slpb_pkg::OP_RENDER: begin
        if (m_flash_on && e.now > m_expiry) m_flash_on = 1'b0;
        if (m_flash_on) begin
          rgb = m_seen ? scale_rgb(m_layer, m_flash) : {16'h0, m_solid};
        end else if (m_switch) begin
          per = (m_period == 0) ? 64'd1 : 64'(m_period);
          idx = ((64'(e.now) % per) * 64'(slpb_pkg::WAVE_TABLE_SIZE)) / per;
          lvl = 64'(m_min) << 15;
          if (m_max >= m_min) lvl += 64'(m_max - m_min) * 64'(wave_q15[idx]);
          else lvl -= 64'(m_min - m_max) * 64'(wave_q15[idx]);
          c = (m_layer == 0) ? slpb_pkg::GREEN_RGB : m_layer;
          for (int k = 0; k < 3; k++)
            ch[k] = 8'((64'((c >> (16 - 8 * k)) & 24'hFF) * lvl) / (64'd255 * 64'd32768));
          rgb = {ch[2], ch[1], ch[0]};
        end else if (m_base == slpb_pkg::ST_MIC_STRM) rgb = {m_solid, 16'h0};
        else if (m_hid)                               rgb = {8'h0, m_solid, m_solid};
        else if (m_base == slpb_pkg::ST_WAIT)         rgb = {16'h0, m_solid};
        else if (m_base == slpb_pkg::ST_CONNECTED)    rgb = scale_rgb(m_layer, m_conn);
        else                                          rgb = '0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Driver: a random gap before each request, then hold valid until taken.
  int src_gap = 0;
  led_event_t cur_event;
  always @(posedge clk_i) begin
    logic [23:0] rgb;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_led(cur_event, rgb)) rgb_expected_q.push_back(rgb);
        n_events++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (event_q.size() > 0) begin
          cur_event = event_q.pop_front();
          s_axis_tuser <= cur_event.op;
          s_axis_tdata <= {4'h0, cur_event.now, cur_event.rgb, cur_event.flag,
                           cur_event.code};
          s_axis_tvalid <= 1'b1;
          src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: a random wait before taking each color, then compare it.
  int snk_gap = 0;
  always @(posedge clk_i) begin
    logic [23:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_renders++;
        if (rgb_expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
          n_errors++;
        end else begin
          want = rgb_expected_q.pop_front();
          if (want !== m_axis_tdata) begin
            $display("%0t: rgb expected %h actual %h", $realtime, want, m_axis_tdata);
            n_errors++;
          end
        end
        snk_gap = $urandom_range(0, 7);
      end
      if (snk_gap > 0) begin
        snk_gap = snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      slpb_pkg::REG_PERIOD:   m_period = val[23:0];
      slpb_pkg::REG_MIN:      m_min = val[7:0];
      slpb_pkg::REG_MAX:      m_max = val[7:0];
      slpb_pkg::REG_DURATION: m_duration = val[23:0];
      slpb_pkg::REG_FLASH:    m_flash = val[7:0];
      slpb_pkg::REG_CONN:     m_conn = val[7:0];
      slpb_pkg::REG_SOLID:    m_solid = val[7:0];
      default: ;
    endcase
  endtask

  // Wait until all queued requests went in and all colors came out,
  // then let the clock run on past the end of a breathing render.
  task automatic drain();
    while (event_q.size() > 0 || s_axis_tvalid || rgb_expected_q.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  logic [47:0] clock_us = '0;

  task automatic push_event(logic [2:0] op, logic [2:0] code, logic flag,
                            logic [23:0] rgb, logic [47:0] now);
    led_event_t e;
    e.op = op; e.code = code; e.flag = flag; e.rgb = rgb; e.now = now;
    event_q.push_back(e);
  endtask

  // Random event with a time stamp that mostly creeps forward.
  task automatic push_random();
    logic [2:0] op;
    logic [23:0] rgb;
    int r;
    r = $urandom_range(0, 99);
    op = (r < 45) ? slpb_pkg::OP_RENDER : (r < 60) ? slpb_pkg::OP_SET_LAYER :
         (r < 72) ? slpb_pkg::OP_SET_STATE : (r < 82) ? slpb_pkg::OP_SET_HID :
         (r < 94) ? slpb_pkg::OP_SET_SWITCH : 3'($urandom_range(5, 7));
    case ($urandom_range(0, 9))
      0:       clock_us = clock_us + 48'($urandom);
      1:       clock_us = clock_us + 48'($urandom_range(0, 3));
      default: clock_us = clock_us + 48'($urandom_range(0, 150000));
    endcase
    rgb = ($urandom_range(0, 9) == 0) ? 24'h0 : 24'($urandom);
    push_event(op, 3'($urandom_range(0, 7)), 1'($urandom), rgb, clock_us);
  endtask

  task automatic write_all(logic [23:0] per, logic [7:0] mn, logic [7:0] mx,
                           logic [23:0] dur, logic [7:0] fl, logic [7:0] cn,
                           logic [7:0] sl);
    apb_write(slpb_pkg::REG_PERIOD, 32'(per));
    apb_write(slpb_pkg::REG_MIN, 32'(mn));
    apb_write(slpb_pkg::REG_MAX, 32'(mx));
    apb_write(slpb_pkg::REG_DURATION, 32'(dur));
    apb_write(slpb_pkg::REG_FLASH, 32'(fl));
    apb_write(slpb_pkg::REG_CONN, 32'(cn));
    apb_write(slpb_pkg::REG_SOLID, 32'(sl));
  endtask

  initial begin
    fill_wave();
    m_period = 24'd1500000; m_min = 8'd6; m_max = 8'd40; m_duration = 24'd200000;
    m_flash = 8'd36; m_conn = 8'd20; m_solid = 8'd24;
    m_base = slpb_pkg::ST_WAIT; m_hid = 0; m_layer = slpb_pkg::GREEN_RGB; m_seen = 0;
    m_switch = 0; m_flash_on = 0; m_expiry = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset colors, key-press codes ignored, black layer, flash edge,
    // breathing, priorities, off codes, unknown opcodes, time saturation.
    push_event(slpb_pkg::OP_RENDER, 0, 0, 0, 48'd0);
    push_event(slpb_pkg::OP_SET_LAYER, 0, 0, 24'h0, 48'd10);
    push_event(slpb_pkg::OP_RENDER, 0, 0, 0, 48'd200010);
    push_event(slpb_pkg::OP_SET_STATE, slpb_pkg::ST_HID_PRESS, 0, 0, 48'd200010);
    push_event(slpb_pkg::OP_SET_STATE, slpb_pkg::ST_MIC_PRESS, 0, 0, 48'd200010);
    push_event(slpb_pkg::OP_RENDER, 0, 0, 0, 48'd200010);
    push_event(slpb_pkg::OP_RENDER, 0, 0, 0, 48'd200011);
    push_event(slpb_pkg::OP_SET_STATE, slpb_pkg::ST_CONNECTED, 1, 24'hFFFFFF, 48'd200012);
    push_event(slpb_pkg::OP_RENDER, 0, 0, 0, 48'd200013);
    push_event(slpb_pkg::OP_SET_HID, 0, 1, 0, 48'd200014);
    push_event(slpb_pkg::OP_RENDER, 0, 0, 0, 48'd200015);
    push_event(slpb_pkg::OP_SET_STATE, slpb_pkg::ST_MIC_STRM, 0, 0, 48'd200016);
    push_event(slpb_pkg::OP_RENDER, 0, 0, 0, 48'd200017);
    push_event(slpb_pkg::OP_SET_SWITCH, 0, 1, 0, 48'd200018);
    push_event(slpb_pkg::OP_RENDER, 0, 0, 0, 48'd949999);
    push_event(3'd5, 7, 1, 24'hFFFFFF, 48'd950000);
    push_event(3'd7, 0, 0, 0, 48'd950000);
    push_event(slpb_pkg::OP_SET_SWITCH, 0, 0, 0, 48'd950001);
    push_event(slpb_pkg::OP_SET_HID, 0, 0, 0, 48'd950001);
    push_event(slpb_pkg::OP_SET_STATE, 3'd7, 0, 0, 48'd950002);
    push_event(slpb_pkg::OP_RENDER, 0, 0, 0, 48'd950003);
    push_event(slpb_pkg::OP_SET_LAYER, 0, 0, 24'hFF00FF, TIME_MAX - 48'd5);
    push_event(slpb_pkg::OP_RENDER, 0, 0, 0, TIME_MAX);
    drain();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_all(24'd1500000, 8'd6, 8'd40, 24'd200000, 8'd36, 8'd20, 8'd24);
        1: write_all(24'd0, 8'd255, 8'd0, 24'd0, 8'd255, 8'd255, 8'd255);
        2: write_all(24'hFFFFFF, 8'd0, 8'd255, 24'hFFFFFF, 8'd0, 8'd0, 8'd0);
        3: write_all(24'd1, 8'd200, 8'd10, 24'd1, 8'd128, 8'd77, 8'd1);
        default: write_all(24'($urandom_range(1, 400000)), 8'($urandom), 8'($urandom),
                           24'($urandom_range(0, 300000)), 8'($urandom),
                           8'($urandom), 8'($urandom));
      endcase
      clock_us = (ph == 4) ? TIME_MAX - 48'd20000000 : 48'($urandom);
      for (int i = 0; i < N_RANDOM / 5; i++) push_random();
      drain();
    end

    $display("Ran %0d events with %0d renders over five register settings,",
             n_events, n_renders);
    $display("covering flash, breathing, state priority and time saturation.");
    if (n_errors == 0 && rgb_expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
